[rtl/first_fit_heap_allocator_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the first-fit heap allocator.
// Shared helpers for concurrent checks on clk with active-low reset.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH

// Same-cycle implication.
`define FFHA_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define FFHA_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/ffha_pkg.sv]
// ----------------------------------------------------------------------------
// ffha_pkg
// Types and constants shared by the heap allocator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ffha_pkg;

    localparam int FFHA_MAX_SEGMENTS = 64;
    localparam int FFHA_HEADER_BYTES = 12;
    localparam int FFHA_SPLIT_SLACK  = 8;

    localparam logic [31:0] HEAP_SIZE_RESET = 32'd65536;

    // Request modes.
    localparam logic [1:0] MODE_ALLOC   = 2'd0;
    localparam logic [1:0] MODE_RELEASE = 2'd1;
    localparam logic [1:0] MODE_REALLOC = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOFIT    = 2'd1;
    localparam logic [1:0] ST_RELEASED = 2'd2;
    localparam logic [1:0] ST_UNKNOWN  = 2'd3;

    // Configuration register indexes.
    localparam logic REG_HEAP_BASE = 1'b0;
    localparam logic REG_HEAP_SIZE = 1'b1;

    // One segment table entry.
    typedef struct packed {
        logic [31:0] offset;
        logic [31:0] size;
        logic        free;
    } seg_entry_t;

    // Operands of the shared adder.
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
    } alu_req_t;

endpackage

`default_nettype wire

[rtl/ffha_ram.sv]
// ----------------------------------------------------------------------------
// ffha_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ffha_ram #(
    parameter int WIDTH = 65,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[rtl/ffha_alu.sv]
// ----------------------------------------------------------------------------
// ffha_alu
// Shared three-input adder; compares are done as a + ~b + 1 with the carry.
// ----------------------------------------------------------------------------
`default_nettype none

module ffha_alu (
    input  ffha_pkg::alu_req_t req,
    output logic [32:0]        sum
);

    import ffha_pkg::*;

    assign sum = {1'b0, req.a} + {1'b0, req.b} + {1'b0, req.c};

endmodule

`default_nettype wire

[rtl/first_fit_heap_allocator.sv]
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit heap segment allocator with coalescing, driven by one shared
// adder under a small sequencer that walks the segment table in a RAM.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake               Payload
//   --------  ----------------------  ----------------------------------------
//   request   start & !busy           mode, request_bytes, address
//   result    done (one cycle)        result_address, status, copy_source,
//                                     copy_bytes
//   config    cfg_valid & cfg_ready   cfg_index, cfg_data
//
// Every table step is a RAM read, then a check through the adder (a write in
// the tail shift); the scans of a request are drawn from a lookup, a first-fit
// search, a shift of the tail on a split and a merge pass.
// After reset, and after every write of heap_size, the S_BOOT state rebuilds
// the table as one free segment; busy is high in that state.
// The result strobe cannot be stalled by the receiver; each transfer is one
// cycle of done, and the block is busy until that cycle ends.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_heap_allocator #(
    parameter int MAX_SEGMENTS = ffha_pkg::FFHA_MAX_SEGMENTS,
    parameter int HEADER_BYTES = ffha_pkg::FFHA_HEADER_BYTES,
    parameter int SPLIT_SLACK  = ffha_pkg::FFHA_SPLIT_SLACK
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  mode,
    input  wire logic [23:0] request_bytes,
    input  wire logic [31:0] address,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_data,
    output logic             done,
    output logic [31:0]      result_address,
    output logic [1:0]       status,
    output logic [31:0]      copy_source,
    output logic [31:0]      copy_bytes
);

    import ffha_pkg::*;

    localparam int IW = $clog2(MAX_SEGMENTS);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam logic [31:0] HDR   = 32'(HEADER_BYTES);
    localparam logic [31:0] SLACK = 32'(SPLIT_SLACK);
    localparam logic [CW-1:0] CMAX = CW'(MAX_SEGMENTS);

    typedef enum logic [4:0] {
        S_BOOT, S_IDLE, S_LK_RD, S_LK_CHK, S_RA_CMP,
        S_AL_PREP, S_AL_THR, S_AL_RD, S_AL_CHK, S_AL_SPL,
        S_SH_RD, S_SH_WR, S_AL_OFF, S_AL_NEW, S_AL_OLD, S_AL_ADDR,
        S_CO_RD, S_CO_CHK, S_DONE
    } state_t;

    // What a lookup hands over to once it has found the segment.
    typedef enum logic [1:0] {
        LK_RELEASE, LK_REALLOC, LK_MOVED
    } lk_kind_t;

    state_t      state_reg;
    lk_kind_t    kind_reg;
    logic [31:0] base_reg;
    logic [31:0] hsize_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] i_reg;
    logic [CW-1:0] j_reg;
    logic [CW-1:0] m_reg;
    logic [CW-1:0] k_reg;
    logic [23:0] req_reg;
    logic [31:0] addr_reg;
    logic [31:0] sz_reg;
    logic [31:0] szh_reg;
    logic [31:0] thr_reg;
    logic [31:0] old_reg;
    logic [31:0] off_tmp_reg;
    logic        moving_reg;
    logic        split_reg;
    seg_entry_t  ent_reg;
    seg_entry_t  prev_reg;
    logic [31:0] res_reg;
    logic [1:0]  status_reg;
    logic [31:0] csrc_reg;
    logic [31:0] cbytes_reg;

    alu_req_t    alu_req;
    logic [32:0] alu_sum;

    logic        ram_we;
    logic [IW-1:0] ram_waddr;
    seg_entry_t  ram_wdata;
    logic [IW-1:0] ram_raddr;
    seg_entry_t  rd;
    seg_entry_t  cur;
    logic        merge;
    logic [CW-1:0] i_inc;
    logic [CW-1:0] j_dec;
    logic [CW-1:0] m_dec;

    logic accept;
    logic cfg_write;

    assign busy      = (state_reg != S_IDLE);
    assign done      = (state_reg == S_DONE);
    assign cfg_ready = (state_reg == S_IDLE) && !start;
    assign accept    = start && !busy;
    assign cfg_write = cfg_valid && cfg_ready;

    assign result_address = res_reg;
    assign status         = status_reg;
    assign copy_source    = csrc_reg;
    assign copy_bytes     = cbytes_reg;

    assign i_inc = i_reg + CW'(1);
    assign j_dec = j_reg - CW'(1);
    assign m_dec = m_reg - CW'(1);

    // Entry under the merge pass; the released segment is marked free here.
    always_comb
    begin
        cur = rd;
        if (i_reg == k_reg)
        begin
            cur.free = 1'b1;
        end
    end

    assign merge = (j_reg != '0) && prev_reg.free && cur.free;

    // Operand selection for the shared adder.
    always_comb
    begin
        alu_req = '0;
        case (state_reg)
            S_BOOT:    alu_req = '{a: hsize_reg, b: ~HDR, c: 32'd1};
            S_LK_CHK:  alu_req = '{a: base_reg, b: rd.offset, c: HDR};
            S_RA_CMP:  alu_req = '{a: ent_reg.size, b: ~{8'd0, req_reg}, c: 32'd1};
            S_AL_PREP: alu_req = '{a: sz_reg, b: 32'd0, c: HDR};
            S_AL_THR:  alu_req = '{a: szh_reg, b: SLACK, c: 32'd0};
            S_AL_CHK:  alu_req = '{a: rd.size, b: ~sz_reg, c: 32'd1};
            S_AL_SPL:  alu_req = '{a: ent_reg.size, b: ~thr_reg, c: 32'd0};
            S_AL_OFF:  alu_req = '{a: ent_reg.offset, b: szh_reg, c: 32'd0};
            S_AL_NEW:  alu_req = '{a: ent_reg.size, b: ~szh_reg, c: 32'd1};
            S_AL_ADDR: alu_req = '{a: base_reg, b: ent_reg.offset, c: HDR};
            S_CO_CHK:  alu_req = '{a: prev_reg.size, b: cur.size, c: HDR};
            default:   alu_req = '0;
        endcase
    end

    ffha_alu u_alu (
        .req (alu_req),
        .sum (alu_sum)
    );

    // Table port selection.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_raddr = i_reg[IW-1:0];
        case (state_reg)
            S_BOOT:
            begin
                ram_we    = 1'b1;
                ram_wdata = '{offset: 32'd0,
                              size: alu_sum[32] ? alu_sum[31:0] : 32'd0,
                              free: 1'b1};
            end
            S_SH_RD:
            begin
                ram_raddr = m_dec[IW-1:0];
            end
            S_SH_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = m_reg[IW-1:0];
                ram_wdata = rd;
            end
            S_AL_NEW:
            begin
                ram_we    = 1'b1;
                ram_waddr = i_inc[IW-1:0];
                ram_wdata = '{offset: off_tmp_reg, size: alu_sum[31:0], free: 1'b1};
            end
            S_AL_OLD:
            begin
                ram_we    = 1'b1;
                ram_waddr = i_reg[IW-1:0];
                ram_wdata = '{offset: ent_reg.offset,
                              size: split_reg ? sz_reg : ent_reg.size,
                              free: 1'b0};
            end
            S_CO_CHK:
            begin
                ram_we = 1'b1;
                if (merge)
                begin
                    ram_waddr = j_dec[IW-1:0];
                    ram_wdata = '{offset: prev_reg.offset, size: alu_sum[31:0],
                                  free: 1'b1};
                end
                else
                begin
                    ram_waddr = j_reg[IW-1:0];
                    ram_wdata = cur;
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    ffha_ram #(
        .WIDTH ($bits(seg_entry_t)),
        .DEPTH (MAX_SEGMENTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (rd)
    );

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_BOOT;
            kind_reg    <= LK_RELEASE;
            base_reg    <= '0;
            hsize_reg   <= HEAP_SIZE_RESET;
            count_reg   <= CW'(1);
            i_reg       <= '0;
            j_reg       <= '0;
            m_reg       <= '0;
            k_reg       <= '0;
            req_reg     <= '0;
            addr_reg    <= '0;
            sz_reg      <= '0;
            szh_reg     <= '0;
            thr_reg     <= '0;
            old_reg     <= '0;
            off_tmp_reg <= '0;
            moving_reg  <= 1'b0;
            split_reg   <= 1'b0;
            ent_reg     <= '0;
            prev_reg    <= '0;
            res_reg     <= '0;
            status_reg  <= ST_OK;
            csrc_reg    <= '0;
            cbytes_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                S_BOOT:
                begin
                    count_reg <= CW'(1);
                    state_reg <= S_IDLE;
                end

                S_IDLE:
                begin
                    if (cfg_write)
                    begin
                        if (cfg_index == REG_HEAP_BASE)
                        begin
                            base_reg <= cfg_data;
                        end
                        else
                        begin
                            hsize_reg <= cfg_data;
                            state_reg <= S_BOOT;
                        end
                    end
                    else if (accept)
                    begin
                        req_reg    <= request_bytes;
                        addr_reg   <= address;
                        sz_reg     <= ({8'd0, request_bytes} + 32'd3) & ~32'd3;
                        res_reg    <= '0;
                        status_reg <= ST_OK;
                        csrc_reg   <= '0;
                        cbytes_reg <= '0;
                        moving_reg <= 1'b0;
                        k_reg      <= CMAX;
                        i_reg      <= '0;
                        if (mode == MODE_ALLOC || (mode == MODE_REALLOC && address == '0))
                        begin
                            state_reg <= (request_bytes == '0) ? S_DONE : S_AL_PREP;
                        end
                        else if (mode == MODE_RELEASE)
                        begin
                            kind_reg  <= LK_RELEASE;
                            state_reg <= (address == '0) ? S_DONE : S_LK_RD;
                        end
                        else if (mode == MODE_REALLOC)
                        begin
                            kind_reg  <= LK_REALLOC;
                            state_reg <= S_LK_RD;
                        end
                        else
                        begin
                            state_reg <= S_DONE;
                        end
                    end
                end

                // Lookup of a payload address.
                S_LK_RD:
                begin
                    if (i_reg == count_reg)
                    begin
                        if (kind_reg != LK_MOVED)
                        begin
                            status_reg <= ST_UNKNOWN;
                        end
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_LK_CHK;
                    end
                end

                S_LK_CHK:
                begin
                    if (alu_sum[31:0] == addr_reg)
                    begin
                        k_reg   <= i_reg;
                        ent_reg <= rd;
                        i_reg   <= '0;
                        j_reg   <= '0;
                        case (kind_reg)
                            LK_REALLOC:
                            begin
                                if (req_reg == '0)
                                begin
                                    status_reg <= ST_RELEASED;
                                    state_reg  <= S_CO_RD;
                                end
                                else
                                begin
                                    state_reg <= S_RA_CMP;
                                end
                            end
                            default:
                            begin
                                state_reg <= S_CO_RD;
                            end
                        endcase
                    end
                    else
                    begin
                        i_reg     <= i_inc;
                        state_reg <= S_LK_RD;
                    end
                end

                S_RA_CMP:
                begin
                    if (alu_sum[32])
                    begin
                        res_reg   <= addr_reg;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        old_reg    <= ent_reg.size;
                        moving_reg <= 1'b1;
                        state_reg  <= S_AL_PREP;
                    end
                end

                // First-fit allocation.
                S_AL_PREP:
                begin
                    szh_reg   <= alu_sum[31:0];
                    state_reg <= S_AL_THR;
                end

                S_AL_THR:
                begin
                    thr_reg   <= alu_sum[31:0];
                    i_reg     <= '0;
                    state_reg <= S_AL_RD;
                end

                S_AL_RD:
                begin
                    if (i_reg == count_reg)
                    begin
                        res_reg    <= '0;
                        status_reg <= ST_NOFIT;
                        state_reg  <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_AL_CHK;
                    end
                end

                S_AL_CHK:
                begin
                    if (rd.free && alu_sum[32])
                    begin
                        ent_reg   <= rd;
                        state_reg <= S_AL_SPL;
                    end
                    else
                    begin
                        i_reg     <= i_inc;
                        state_reg <= S_AL_RD;
                    end
                end

                S_AL_SPL:
                begin
                    if (alu_sum[32] && count_reg != CMAX)
                    begin
                        split_reg <= 1'b1;
                        m_reg     <= count_reg;
                        state_reg <= S_SH_RD;
                    end
                    else
                    begin
                        split_reg <= 1'b0;
                        state_reg <= S_AL_OLD;
                    end
                end

                // Move the tail up by one entry to open a slot after the fit.
                S_SH_RD:
                begin
                    state_reg <= (m_reg == i_inc) ? S_AL_OFF : S_SH_WR;
                end

                S_SH_WR:
                begin
                    m_reg     <= m_dec;
                    state_reg <= S_SH_RD;
                end

                S_AL_OFF:
                begin
                    off_tmp_reg <= alu_sum[31:0];
                    state_reg   <= S_AL_NEW;
                end

                S_AL_NEW:
                begin
                    count_reg <= count_reg + CW'(1);
                    state_reg <= S_AL_OLD;
                end

                S_AL_OLD:
                begin
                    state_reg <= S_AL_ADDR;
                end

                S_AL_ADDR:
                begin
                    res_reg <= alu_sum[31:0];
                    if (moving_reg)
                    begin
                        csrc_reg   <= addr_reg;
                        cbytes_reg <= old_reg;
                        kind_reg   <= LK_MOVED;
                        i_reg      <= '0;
                        state_reg  <= S_LK_RD;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end

                // Merge pass: compact the table, folding runs of free segments.
                S_CO_RD:
                begin
                    if (i_reg == count_reg)
                    begin
                        count_reg <= j_reg;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_CO_CHK;
                    end
                end

                S_CO_CHK:
                begin
                    if (merge)
                    begin
                        prev_reg.size <= alu_sum[31:0];
                    end
                    else
                    begin
                        prev_reg <= cur;
                        j_reg    <= j_reg + CW'(1);
                    end
                    i_reg     <= i_inc;
                    state_reg <= S_CO_RD;
                end

                S_DONE:
                begin
                    state_reg <= S_IDLE;
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/ffha_checker.sv]
// ----------------------------------------------------------------------------
// ffha_checker
// Port-level checks on the heap allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "first_fit_heap_allocator_assert.svh"

module ffha_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        cfg_ready,
    input wire logic        done,
    input wire logic [31:0] result_address,
    input wire logic [1:0]  status
);

    import ffha_pkg::*;

    `FFHA_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "no busy after request transfer")
    `FFHA_ASSERT_IMPL(a_done_busy, done, busy, "result strobe while idle")
    `FFHA_ASSERT_NEXT(a_done_single, done, !done, "result strobe longer than one cycle")
    `FFHA_ASSERT_IMPL(a_cfg_idle, cfg_ready, !busy, "config ready while busy")
    `FFHA_ASSERT_IMPL(a_fail_null, done && (status == ST_NOFIT || status == ST_UNKNOWN),
                      result_address == '0, "failed request returned an address")

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .cfg_ready      (cfg_ready),
    .done           (done),
    .result_address (result_address),
    .status         (status)
);

`default_nettype wire

[tb/first_fit_heap_allocator_tb.sv]
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_tb
// Self-checking bench for the first-fit heap allocator. A queue of requests,
// filled by phases in an initial block, feeds a falling-edge driver. A
// rising-edge monitor compares every result transfer with a segment table
// model kept inside the bench. Configuration writes happen only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_heap_allocator_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import ffha_pkg::*;

    localparam int NSEG      = FFHA_MAX_SEGMENTS;
    localparam int HDR       = FFHA_HEADER_BYTES;
    localparam int SLACK     = FFHA_SPLIT_SLACK;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic [1:0]  mode;
        logic [23:0] req;
        logic [31:0] addr;
    } heap_req_t;

    typedef struct packed {
        logic [31:0] res;
        logic [1:0]  st;
        logic [31:0] src;
        logic [31:0] cnt;
    } heap_rsp_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [1:0]  mode = '0;
    logic [23:0] request_bytes = '0;
    logic [31:0] address = '0;
    logic        cfg_valid = 1'b0;
    logic        cfg_index = 1'b0;
    logic [31:0] cfg_data = '0;
    wire         busy, cfg_ready, done;
    wire  [31:0] result_address, copy_source, copy_bytes;
    wire  [1:0]  status;

    first_fit_heap_allocator dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .mode(mode), .request_bytes(request_bytes), .address(address),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .done(done), .result_address(result_address),
        .status(status), .copy_source(copy_source), .copy_bytes(copy_bytes)
    );

    always #1 clk = ~clk;

    // Model of the segment table.
    logic [31:0] m_base, m_size;
    logic [31:0] m_off [NSEG];
    logic [31:0] m_len [NSEG];
    logic        m_free [NSEG];
    int          m_count;

    heap_req_t pending_reqs [$];
    heap_rsp_t expected_rsps [$];
    int        errors = 0;
    int        idle_cycles = 0;
    bit        quiet_sender = 0;   // no random gaps while set
    bit        hold_sender = 0;    // phase boundary: driver stops
    bit        in_taken = 0;       // request transfer at the last rising edge

    // Live addresses handed out, used to build realistic frees/reallocs.
    logic [31:0] live_addrs [$];

    function automatic void table_reset();
        m_off[0] = '0;
        m_len[0] = (m_size >= HDR) ? m_size - HDR : '0;
        m_free[0] = 1'b1;
        m_count = 1;
    endfunction

    function automatic logic [31:0] payload_of(int i);
        return m_base + m_off[i] + HDR;
    endfunction

    function automatic int find_seg(logic [31:0] a);
        for (int i = 0; i < m_count; i++)
            if (payload_of(i) == a) return i;
        return m_count;
    endfunction

    function automatic void merge_free();
        int j;
        j = 0;
        for (int i = 0; i < m_count; i++) begin
            if (j > 0 && m_free[j-1] && m_free[i]) begin
                m_len[j-1] = m_len[j-1] + HDR + m_len[i];
            end
            else begin
                m_off[j] = m_off[i];
                m_len[j] = m_len[i];
                m_free[j] = m_free[i];
                j++;
            end
        end
        m_count = j;
    endfunction

    // First-fit take; returns 1 on success with the payload address in a.
    function automatic bit take_first_fit(logic [23:0] req, output logic [31:0] a);
        logic [31:0] sz;
        int i;
        sz = ({8'd0, req} + 32'd3) & ~32'd3;
        a = '0;
        for (i = 0; i < m_count; i++)
            if (m_free[i] && m_len[i] >= sz) break;
        if (i >= m_count) return 0;
        m_free[i] = 1'b0;
        if ({32'd0, m_len[i]} > {32'd0, sz} + HDR + SLACK && m_count < NSEG) begin
            for (int m = m_count; m > i + 1; m--) begin
                m_off[m] = m_off[m-1];
                m_len[m] = m_len[m-1];
                m_free[m] = m_free[m-1];
            end
            m_off[i+1] = m_off[i] + HDR + sz;
            m_len[i+1] = m_len[i] - sz - HDR;
            m_free[i+1] = 1'b1;
            m_len[i] = sz;
            m_count++;
        end
        a = payload_of(i);
        return 1;
    endfunction

    function automatic heap_rsp_t predict_heap(heap_req_t r);
        heap_rsp_t o;
        int k;
        logic [31:0] old_len, a;
        o = '0;
        if (r.mode == MODE_ALLOC || (r.mode == MODE_REALLOC && r.addr == 0)) begin
            if (r.req != 0) begin
                if (take_first_fit(r.req, a)) o.res = a;
                else o.st = ST_NOFIT;
            end
        end
        else if (r.mode == MODE_RELEASE) begin
            if (r.addr != 0) begin
                k = find_seg(r.addr);
                if (k >= m_count) o.st = ST_UNKNOWN;
                else begin
                    m_free[k] = 1'b1;
                    merge_free();
                end
            end
        end
        else if (r.mode == MODE_REALLOC) begin
            k = find_seg(r.addr);
            if (k >= m_count) o.st = ST_UNKNOWN;
            else if (r.req == 0) begin
                m_free[k] = 1'b1;
                merge_free();
                o.st = ST_RELEASED;
            end
            else if (m_len[k] >= {8'd0, r.req}) o.res = r.addr;
            else begin
                old_len = m_len[k];
                if (!take_first_fit(r.req, a)) o.st = ST_NOFIT;
                else begin
                    o.res = a;
                    o.src = r.addr;
                    o.cnt = old_len;
                    k = find_seg(r.addr);
                    if (k < m_count) begin
                        m_free[k] = 1'b1;
                        merge_free();
                    end
                end
            end
        end
        return o;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Driver: presents queued requests at the falling edge. A request stays
    // on the ports until the monitor has seen its transfer; the model is
    // advanced by the monitor at that edge, so it stays in order.
    always @(negedge clk) begin
        if (rst_n) begin
            if (!(start && !in_taken) && pending_reqs.size() > 0 && !hold_sender &&
                (quiet_sender || $urandom_range(99) >= 9)) begin
                heap_req_t r;
                r = pending_reqs.pop_front();
                start <= 1'b1;
                mode <= r.mode;
                request_bytes <= r.req;
                address <= r.addr;
            end
            else if (!(start && !in_taken)) begin
                start <= 1'b0;
                mode <= 2'($urandom);
                request_bytes <= 24'($urandom);
                address <= $urandom;
            end
        end
    end

    // Monitor: acceptance of requests and results at the rising edge.
    always @(posedge clk) begin
        if (rst_n) begin
            in_taken = start && !busy;
            if (start && !busy) begin
                heap_rsp_t e;
                e = predict_heap('{mode, request_bytes, address});
                expected_rsps.push_back(e);
                if (e.res != 0) live_addrs.push_back(e.res);
            end
            if (done) begin
                heap_rsp_t e;
                if (expected_rsps.size() == 0) begin
                    report_mismatch("unexpected result_address", result_address, 32'd0);
                end
                else begin
                    e = expected_rsps.pop_front();
                    if (result_address !== e.res)
                        report_mismatch("result_address", result_address, e.res);
                    if (status !== e.st)
                        report_mismatch("status", {30'd0, status}, {30'd0, e.st});
                    if (copy_source !== e.src)
                        report_mismatch("copy_source", copy_source, e.src);
                    if (copy_bytes !== e.cnt)
                        report_mismatch("copy_bytes", copy_bytes, e.cnt);
                end
            end
            // Watchdog: cycles without any transfer.
            if ((start && !busy) || done || (cfg_valid && cfg_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic wait_idle();
        while (pending_reqs.size() > 0 || expected_rsps.size() > 0 || start)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    // One register write, held until ready; model updated on the transfer.
    task automatic write_reg(logic idx, logic [31:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        if (idx == REG_HEAP_BASE) m_base = val;
        else begin
            m_size = val;
            table_reset();
        end
        live_addrs.delete();
        @(negedge clk);
        cfg_valid <= 1'b0;
        cfg_data <= $urandom;
        cfg_index <= 1'($urandom);
    endtask

    function automatic logic [23:0] pick_size();
        int c;
        c = $urandom_range(99);
        if (c < 70) return 24'($urandom_range(1, 600));
        if (c < 85) return 24'($urandom_range(0, 4096));
        if (c < 95) return 24'($urandom);
        return 24'hFFFFFF;
    endfunction

    // Addresses come from the set handed out so far (known, possibly freed),
    // with some null and some arbitrary ones for the unknown-address path.
    function automatic logic [31:0] pick_addr();
        int c;
        c = $urandom_range(99);
        if (c < 75 && live_addrs.size() > 0)
            return live_addrs[$urandom_range(live_addrs.size() - 1)];
        if (c < 85) return '0;
        return $urandom;
    endfunction

    // Random requests are built in small batches so that addresses can come
    // from results the model has already produced.
    task automatic random_phase(int n);
        for (int i = 0; i < n; i++) begin
            heap_req_t r;
            int c;
            c = $urandom_range(99);
            r.req = pick_size();
            r.addr = pick_addr();
            if (c < 45) r.mode = MODE_ALLOC;
            else if (c < 75) r.mode = MODE_RELEASE;
            else if (c < 97) r.mode = MODE_REALLOC;
            else r.mode = 2'd3;
            pending_reqs.push_back(r);
            if (pending_reqs.size() > 4)
                while (pending_reqs.size() > 1) @(posedge clk);
        end
    endtask

    initial begin
        m_base = '0;
        m_size = HEAP_SIZE_RESET;
        table_reset();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part: special cases on the reset configuration.
        quiet_sender = 1;
        pending_reqs.push_back('{MODE_ALLOC, 24'd0, 32'd0});
        pending_reqs.push_back('{MODE_ALLOC, 24'd1, 32'd0});
        pending_reqs.push_back('{MODE_ALLOC, 24'd100, 32'd0});
        pending_reqs.push_back('{MODE_ALLOC, 24'hFFFFFF, 32'hFFFFFFFF});
        pending_reqs.push_back('{MODE_RELEASE, 24'd0, 32'd0});
        pending_reqs.push_back('{MODE_RELEASE, 24'd0, 32'd12});
        pending_reqs.push_back('{MODE_RELEASE, 24'd0, 32'd12});
        pending_reqs.push_back('{MODE_RELEASE, 24'd0, 32'h0000_0005});
        pending_reqs.push_back('{MODE_REALLOC, 24'd40, 32'd0});
        pending_reqs.push_back('{MODE_REALLOC, 24'd8, 32'd12});
        pending_reqs.push_back('{MODE_REALLOC, 24'd300, 32'd12});
        pending_reqs.push_back('{MODE_REALLOC, 24'hFFFFFF, 32'd12});
        pending_reqs.push_back('{MODE_REALLOC, 24'd0, 32'd12});
        pending_reqs.push_back('{MODE_REALLOC, 24'd5, 32'hDEAD_BEEF});
        pending_reqs.push_back('{2'd3, 24'hFFFFFF, 32'hFFFFFFFF});
        // Sender pauses until every expected result is in.
        wait_idle();

        // Fill the table to its limit with tiny requests, then churn.
        write_reg(REG_HEAP_BASE, 32'hFFFF_FFF0);
        write_reg(REG_HEAP_SIZE, 32'hFFFF_FFFF);
        for (int i = 0; i < 70; i++)
            pending_reqs.push_back('{MODE_ALLOC, 24'd4, 32'd0});
        wait_idle();
        quiet_sender = 0;
        random_phase(60);
        wait_idle();

        // Small heap below the header size.
        write_reg(REG_HEAP_SIZE, 32'd5);
        pending_reqs.push_back('{MODE_ALLOC, 24'd1, 32'd0});
        pending_reqs.push_back('{MODE_RELEASE, 24'd0, 32'hFFFF_FFFC});
        wait_idle();

        write_reg(REG_HEAP_BASE, 32'h0);
        write_reg(REG_HEAP_SIZE, 32'd0);
        random_phase(20);
        wait_idle();

        // Main random body with a long quiet stretch in the middle.
        write_reg(REG_HEAP_BASE, $urandom);
        write_reg(REG_HEAP_SIZE, 32'd8192);
        random_phase(200);
        quiet_sender = 1;
        random_phase(150);
        quiet_sender = 0;
        wait_idle();
        write_reg(REG_HEAP_BASE, 32'h1000_0000);
        write_reg(REG_HEAP_SIZE, 32'd2000);
        random_phase(200);
        wait_idle();

        if (errors == 0 && expected_rsps.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire

[first_fit_heap_allocator.f]
+incdir+rtl
rtl/ffha_pkg.sv
rtl/ffha_ram.sv
rtl/ffha_alu.sv
rtl/first_fit_heap_allocator.sv
rtl/ffha_checker.sv
tb/first_fit_heap_allocator_tb.sv
